// ===== hdl/msc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and round functions for the multi-lane
// SHA-256 compression block.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned IO_LANES  = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS    = 64;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } msc_state_t;

  typedef struct packed {
    logic       write_word;
    logic       load_iv;
    logic       load_vars;
    logic       round_step;
    logic       add_chain;
    logic [5:0] round_idx;
    logic [2:0] out_idx;
  } msc_cmd_t;

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/msc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: collects sixteen word beats, steps 64 rounds, folds the
// result into the chaining state and hands out eight digest beats.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_start,
  output logic                  in_ready,
  output logic                  out_valid,
  output logic                  out_last,
  input  wire logic             out_ready,
  output msc_pkg::msc_cmd_t     cmd
);

  msc_pkg::msc_state_t state, state_next;
  logic [5:0]          count, count_next;
  logic                in_fire;
  logic                out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msc_pkg::ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_last       = 1'b0;
    cmd            = '0;
    cmd.round_idx  = count;
    cmd.out_idx    = count[2:0];
    in_fire        = in_valid;
    out_fire       = out_ready;
    case (state)
      msc_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.write_word = 1'b1;
          // start flag only counts on the first word of a block
          cmd.load_iv    = in_start && (count[3:0] == 4'd0);
          if (count[3:0] == 4'd15) begin
            cmd.load_vars = 1'b1;
            count_next    = '0;
            state_next    = msc_pkg::ST_ROUND;
          end else begin
            count_next = 6'(count + 6'd1);
          end
        end
      end
      msc_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (count == 6'd63) begin
          count_next = '0;
          state_next = msc_pkg::ST_ADD;
        end else begin
          count_next = 6'(count + 6'd1);
        end
      end
      msc_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
        state_next    = msc_pkg::ST_EMIT;
      end
      msc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = (count[2:0] == 3'd7);
        if (out_fire) begin
          if (count[2:0] == 3'd7) begin
            count_next = '0;
            state_next = msc_pkg::ST_LOAD;
          end else begin
            count_next = 6'(count + 6'd1);
          end
        end
      end
      default: begin
        state_next = msc_pkg::ST_LOAD;
        count_next = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/msc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_datapath
// Per-lane chaining state, sixteen-word schedule window and round
// variables, with one compression round per lane per cycle.
// ----------------------------------------------------------------------------
module msc_datapath #(
  parameter int unsigned LANES = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire msc_pkg::msc_cmd_t                       cmd,
  input  wire logic [msc_pkg::IO_LANES*32-1:0]         in_words,
  output logic      [msc_pkg::IO_LANES*32-1:0]         out_words
);

  logic [31:0] chain [LANES][8];
  logic [31:0] vars  [LANES][8];
  logic [31:0] win   [LANES][16];
  logic [31:0] k_t;

  assign k_t = msc_pkg::ROUND_K[cmd.round_idx];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [31:0] word_in;
    logic [31:0] w_new;
    logic [31:0] t1, t2;

    if (l < msc_pkg::IO_LANES) begin : g_io
      assign word_in = in_words[32*l +: 32];
    end else begin : g_zero
      assign word_in = '0;
    end

    // window holds w[t..t+15]; produce w[t+16] as the window slides
    assign w_new = msc_pkg::small_sigma1(win[l][14]) + win[l][9]
                 + msc_pkg::small_sigma0(win[l][1]) + win[l][0];

    assign t1 = vars[l][7] + msc_pkg::big_sigma1(vars[l][4])
              + ((vars[l][4] & vars[l][5]) ^ (~vars[l][4] & vars[l][6]))
              + k_t + win[l][0];
    assign t2 = msc_pkg::big_sigma0(vars[l][0])
              + ((vars[l][0] & vars[l][1]) ^ (vars[l][0] & vars[l][2])
                 ^ (vars[l][1] & vars[l][2]));

    always_ff @(posedge clk) begin
      if (cmd.write_word || cmd.round_step) begin
        for (int i = 0; i < 15; i++) begin
          win[l][i] <= win[l][i+1];
        end
        win[l][15] <= cmd.write_word ? word_in : w_new;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_vars) begin
        for (int i = 0; i < 8; i++) begin
          vars[l][i] <= chain[l][i];
        end
      end else if (cmd.round_step) begin
        vars[l][7] <= vars[l][6];
        vars[l][6] <= vars[l][5];
        vars[l][5] <= vars[l][4];
        vars[l][4] <= vars[l][3] + t1;
        vars[l][3] <= vars[l][2];
        vars[l][2] <= vars[l][1];
        vars[l][1] <= vars[l][0];
        vars[l][0] <= t1 + t2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst || cmd.load_iv) begin
        for (int i = 0; i < 8; i++) begin
          chain[l][i] <= msc_pkg::INIT_HASH[i];
        end
      end else if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain[l][i] <= chain[l][i] + vars[l][i];
        end
      end
    end
  end

  for (genvar l = 0; l < msc_pkg::IO_LANES; l++) begin : g_out
    if (l < LANES) begin : g_live
      assign out_words[32*l +: 32] = chain[l][cmd.out_idx];
    end else begin : g_absent
      assign out_words[32*l +: 32] = '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/multi_lane_sha256_compress.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_lane_sha256_compress
// SHA-256 block compression over LANES independent messages in parallel.
// ----------------------------------------------------------------------------
// Each input beat carries one big-endian message word per lane; sixteen
// beats form a block, and tuser on the first beat reloads the standard
// initial value before that block. A block takes 16 input beats (one per
// cycle while tvalid is high), 64 rounds (one round per lane per cycle in
// a single shared round unit per lane, with the schedule produced alongside
// in a sliding 16-word window), a fold into the chaining state and then 8
// output beats, one per chaining word, tlast on the eighth. Input is refused
// after the 16th word until the last digest beat is taken. Lanes at or
// above four see zero words; output lanes at or above LANES read zero.
// ----------------------------------------------------------------------------
module multi_lane_sha256_compress #(
  parameter int unsigned LANES = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // word_lane0 [31:0], word_lane1 [63:32], word_lane2 [95:64], word_lane3 [127:96]
  input  wire logic [127:0] s_axis_tdata,
  // start_message [0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // digest_lane0 [31:0], digest_lane1 [63:32], digest_lane2 [95:64], digest_lane3 [127:96]
  output logic      [127:0] m_axis_tdata,
  // digest_index [2:0]
  output logic      [2:0]   m_axis_tuser,
  output logic              m_axis_tlast
);

  msc_pkg::msc_cmd_t cmd;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_start  (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_last  (m_axis_tlast),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  msc_datapath #(
    .LANES (LANES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_words  (s_axis_tdata),
    .out_words (m_axis_tdata)
  );

  assign m_axis_tuser = cmd.out_idx;

`ifndef ASSERT_OFF
  // never collecting words and handing out digests at once
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  // tlast only on the eighth chaining word
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tlast |-> (m_axis_tvalid && m_axis_tuser == 3'd7))
    else $error("tlast on wrong digest index");

  // after the final digest beat the block takes words again
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready for words after last digest beat");

  // digest index steps by one per taken beat within a run
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
      |=> (m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
    else $error("digest index did not advance");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-lane SHA-256 compression block.
// ----------------------------------------------------------------------------
// Feeds whole 16-word blocks into all four lanes and keeps its own per-lane
// chaining state. Every eighth digest beat set is predicted on the block's
// last word and compared beat by beat against the output stream. The run
// opens with a hand-made block (the "abc" message, all ones, all zeros and
// a stray start flag) and then moves on to random blocks. Both stream sides
// idle and stall in several patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int unsigned RANDOM_BLOCKS = 9;

  typedef struct packed {
    logic [127:0] digest;
    logic [2:0]   index;
    logic         last;
  } digest_beat_t;

  class digest_tracker;
    logic [31:0]  chain [msc_pkg::IO_LANES][8];
    logic [31:0]  block_words [msc_pkg::IO_LANES][16];
    int unsigned  word_pos;
    digest_beat_t pending_digests [$];
    int unsigned  mismatches;

    function new();
      word_pos = 0;
      mismatches = 0;
      load_iv();
    endfunction

    function void load_iv();
      for (int l = 0; l < msc_pkg::IO_LANES; l++)
        for (int i = 0; i < 8; i++)
          chain[l][i] = SHA_IV[i];
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_lane(int l);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
        w[t] = block_words[l][t];
      for (int t = 16; t < 64; t++) begin
        s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++)
        v[i] = chain[l][i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
        chain[l][i] = chain[l][i] + v[i];
    endfunction

    // one accepted input beat; the sixteenth of a block yields eight digest beats
    function void note_word(logic [127:0] words, logic start);
      digest_beat_t beat;
      // start flag only counts on the first word of a block
      if (word_pos == 0 && start)
        load_iv();
      for (int l = 0; l < msc_pkg::IO_LANES; l++)
        block_words[l][word_pos] = words[l*32 +: 32];
      if (word_pos != 15) begin
        word_pos++;
        return;
      end
      word_pos = 0;
      for (int l = 0; l < msc_pkg::IO_LANES; l++)
        compress_lane(l);
      for (int k = 0; k < 8; k++) begin
        for (int l = 0; l < msc_pkg::IO_LANES; l++)
          beat.digest[l*32 +: 32] = chain[l][k];
        beat.index = 3'(k);
        beat.last = (k == 7);
        pending_digests.push_back(beat);
      end
    endfunction

    function void report(string what, logic [127:0] want, logic [127:0] got);
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
    endfunction

    function void check_digest(logic [127:0] digest, logic [2:0] index, logic last);
      digest_beat_t want;
      if (pending_digests.size() == 0) begin
        report("unexpected digest beat", '0, digest);
        return;
      end
      want = pending_digests.pop_front();
      for (int l = 0; l < msc_pkg::IO_LANES; l++)
        if (digest[l*32 +: 32] !== want.digest[l*32 +: 32])
          report($sformatf("lane %0d word %0d", l, want.index),
                 128'(want.digest[l*32 +: 32]), 128'(digest[l*32 +: 32]));
      if (index !== want.index)
        report("digest index", 128'(want.index), 128'(index));
      if (last !== want.last)
        report("tlast", 128'(want.last), 128'(last));
    endfunction

    function int unsigned outstanding();
      return pending_digests.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [127:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tready = 1'b0;
  wire          s_axis_tready;
  wire          m_axis_tvalid;
  wire  [127:0] m_axis_tdata;
  wire  [2:0]   m_axis_tuser;
  wire          m_axis_tlast;

  int unsigned  send_idle_pct = 0;
  int unsigned  ready_stall_pct = 0;
  digest_tracker tracker = new();

  multi_lane_sha256_compress uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_word(input logic [127:0] words, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= words;
    s_tuser  <= start;
    do @(negedge clk); while (s_axis_tready !== 1'b1);
    @(posedge clk);
    tracker.note_word(words, start);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // output side: ready is decided at the rising edge, the beat is seen at mid-cycle
  initial begin
    logic         took;
    logic [127:0] got_data;
    logic [2:0]   got_index;
    logic         got_last;
    took = 1'b0;
    forever begin
      @(posedge clk);
      if (took)
        tracker.check_digest(got_data, got_index, got_last);
      m_tready <= ($urandom_range(99) >= ready_stall_pct);
      @(negedge clk);
      took = (m_axis_tvalid === 1'b1) && m_tready;
      got_data = m_axis_tdata;
      got_index = m_axis_tuser;
      got_last = m_axis_tlast;
    end
  end

  initial begin
    #200us;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [127:0] words;
    logic         start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opening block: "abc" in lane 0, extremes elsewhere, no start flag on the
    // first word (initial value after reset) and a stray one mid-block
    for (int w = 0; w < 16; w++) begin
      words[31:0]   = (w == 0) ? 32'h61626380 : (w == 15) ? 32'h00000018 : 32'h0;
      words[63:32]  = '1;
      words[95:64]  = '0;
      words[127:96] = w[0] ? 32'h55555555 : 32'haaaaaaaa;
      send_word(words, w == 7);
    end

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b * 4 / RANDOM_BLOCKS)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 53; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 53; end
        default: begin send_idle_pct = 23; ready_stall_pct = 23; end
      endcase
      for (int w = 0; w < 16; w++) begin
        for (int l = 0; l < msc_pkg::IO_LANES; l++)
          words[l*32 +: 32] = pick_word();
        if (w == 0)
          start = (b % 2 == 0) ? 1'b1 : 1'($urandom_range(1));
        else
          start = ($urandom_range(9) == 0);
        send_word(words, start);
      end
    end
    s_tvalid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
